[hdl/ircf_pkg.sv]
// Shared constants, types and helpers of the IR constant folder.
`timescale 1ns / 1ps
`default_nettype none

package ircf_pkg;

  // Temp store geometry.
  localparam int TEMP_COUNT = 1024;
  localparam int TEMP_W     = $clog2(TEMP_COUNT);

  // Field widths of an instruction item.
  localparam int INDEX_W = 11;
  localparam int DATA_W  = 64;
  localparam int ITER_W  = $clog2(DATA_W);

  // Each store entry carries an epoch tag next to its value; a temp is known
  // when its tag matches the current epoch.
  localparam int EPOCH_W = 8;
  localparam int ENTRY_W = EPOCH_W + DATA_W;

  typedef enum logic [3:0] {
    OP_CONST = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_MOD   = 4'd5,
    OP_LT    = 4'd6,
    OP_GT    = 4'd7,
    OP_LE    = 4'd8,
    OP_GE    = 4'd9,
    OP_EQ    = 4'd10,
    OP_NE    = 4'd11,
    OP_AND   = 4'd12,
    OP_OR    = 4'd13,
    OP_NEG   = 4'd14,
    OP_OTHER = 4'd15
  } opcode_t;

  // Request from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic    start;
    opcode_t op;
  } arith_req_t;

  // Status from the arithmetic unit back to the sequencer.
  typedef struct packed {
    logic done;
    logic ok;
  } arith_rsp_t;

  // A temp index is usable when it is non-negative and below the store depth.
  function automatic logic index_ok(logic signed [INDEX_W-1:0] t);
    return (t >= 0) && (int'(t) < TEMP_COUNT);
  endfunction

endpackage

`default_nettype wire

[hdl/ircf_instr_if.sv]
// Instruction channel: valid/ready handshake with one IR instruction as payload.
`timescale 1ns / 1ps
`default_nettype none

interface ircf_instr_if import ircf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      function_start;
  opcode_t                   opcode;
  logic signed [INDEX_W-1:0] dest_temp;
  logic signed [INDEX_W-1:0] first_source;
  logic signed [INDEX_W-1:0] second_source;
  logic signed [DATA_W-1:0]  immediate;

  modport source (
    output valid, function_start, opcode, dest_temp, first_source, second_source,
           immediate,
    input  ready
  );

  modport sink (
    input  valid, function_start, opcode, dest_temp, first_source, second_source,
           immediate,
    output ready
  );
endinterface

`default_nettype wire

[hdl/ircf_result_if.sv]
// Result channel: valid/ready handshake with the fold outcome as payload.
`timescale 1ns / 1ps
`default_nettype none

interface ircf_result_if import ircf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     folded;
  logic signed [DATA_W-1:0] folded_value;

  modport source (
    output valid, folded, folded_value,
    input  ready
  );

  modport sink (
    input  valid, folded, folded_value,
    output ready
  );
endinterface

`default_nettype wire

[hdl/ircf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ircf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/ircf_arith.sv]
// Iterative 64-bit arithmetic unit built around one shared adder/subtractor.
`timescale 1ns / 1ps
`default_nettype none

module ircf_arith import ircf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  arith_req_t        req,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output arith_rsp_t        rsp,
  output logic [DATA_W-1:0] result
);

  typedef enum logic [2:0] {
    U_IDLE,
    U_NEG_A,
    U_NEG_B,
    U_DIV,
    U_FIX,
    U_MUL
  } ustate_t;

  ustate_t           state;
  opcode_t           op_r;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] mreg;
  logic [DATA_W-1:0] qreg;
  logic [ITER_W-1:0] count;
  logic              a_neg;
  logic              b_neg;

  logic [DATA_W-1:0] add_x;
  logic [DATA_W-1:0] add_y;
  logic              add_sub;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] diff;
  logic              ovf;
  logic              lt;
  logic              eq;
  logic              last;

  // Operand selection for the shared adder, by phase.
  always_comb begin
    add_x   = a;
    add_y   = b;
    add_sub = 1'b1;
    case (state)
      U_IDLE: begin
        if (req.op == OP_ADD) begin
          add_sub = 1'b0;
        end else if (req.op == OP_NEG) begin
          add_x = '0;
          add_y = a;
        end
      end
      U_NEG_A: begin
        add_x = '0;
        add_y = qreg;
      end
      U_NEG_B: begin
        add_x = '0;
        add_y = mreg;
      end
      U_DIV: begin
        add_x = {acc[DATA_W-2:0], qreg[DATA_W-1]};
        add_y = mreg;
      end
      U_FIX: begin
        add_x = '0;
        add_y = (op_r == OP_DIV) ? qreg : acc;
      end
      U_MUL: begin
        add_x   = acc;
        add_y   = mreg;
        add_sub = 1'b0;
      end
      default: begin
        add_sub = 1'b1;
      end
    endcase
  end

  // The shared adder; the carry out means no borrow when subtracting.
  assign sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (DATA_W+1)'(add_sub);

  // Signed compare flags from the difference a - b.
  assign diff = sum[DATA_W-1:0];
  assign ovf  = (a[DATA_W-1] != b[DATA_W-1]) && (diff[DATA_W-1] != a[DATA_W-1]);
  assign lt   = diff[DATA_W-1] ^ ovf;
  assign eq   = (a == b);
  assign last = (count == ITER_W'(DATA_W - 1));

  // Sequencer of the unit: ops without a loop finish straight from idle, multiply and
  // divide iterate one bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= U_IDLE;
      rsp.done <= 1'b0;
      rsp.ok   <= 1'b0;
    end else begin
      case (state)
        U_IDLE: begin
          if (req.start) begin
            op_r <= req.op;
            case (req.op)
              OP_ADD, OP_SUB, OP_NEG: begin
                result   <= diff;
                rsp.ok   <= 1'b1;
                rsp.done <= 1'b1;
              end
              OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ, OP_NE, OP_AND, OP_OR: begin
                rsp.ok   <= 1'b1;
                rsp.done <= 1'b1;
                case (req.op)
                  OP_LT:   result <= DATA_W'(lt);
                  OP_GT:   result <= DATA_W'(!lt && !eq);
                  OP_LE:   result <= DATA_W'(lt || eq);
                  OP_GE:   result <= DATA_W'(!lt);
                  OP_EQ:   result <= DATA_W'(eq);
                  OP_NE:   result <= DATA_W'(!eq);
                  OP_AND:  result <= DATA_W'((a != '0) && (b != '0));
                  default: result <= DATA_W'((a != '0) || (b != '0));
                endcase
              end
              OP_MUL: begin
                acc      <= '0;
                mreg     <= a;
                qreg     <= b;
                count    <= '0;
                rsp.done <= 1'b0;
                state    <= U_MUL;
              end
              OP_DIV, OP_MOD: begin
                if (b == '0) begin
                  // Division by zero does not fold.
                  result   <= '0;
                  rsp.ok   <= 1'b0;
                  rsp.done <= 1'b1;
                end else begin
                  qreg     <= a;
                  mreg     <= b;
                  a_neg    <= a[DATA_W-1];
                  b_neg    <= b[DATA_W-1];
                  rsp.done <= 1'b0;
                  state    <= U_NEG_A;
                end
              end
              default: begin
                result   <= '0;
                rsp.ok   <= 1'b0;
                rsp.done <= 1'b1;
              end
            endcase
          end else begin
            rsp.done <= 1'b0;
          end
        end
        U_MUL: begin
          // Shift-add: add the shifted multiplicand for each set multiplier bit.
          if (qreg[0]) begin
            acc <= sum[DATA_W-1:0];
          end
          mreg  <= {mreg[DATA_W-2:0], 1'b0};
          qreg  <= {1'b0, qreg[DATA_W-1:1]};
          count <= count + ITER_W'(1);
          if (last) begin
            result   <= qreg[0] ? sum[DATA_W-1:0] : acc;
            rsp.ok   <= 1'b1;
            rsp.done <= 1'b1;
            state    <= U_IDLE;
          end else begin
            rsp.done <= 1'b0;
          end
        end
        U_NEG_A: begin
          // Dividend magnitude.
          if (a_neg) begin
            qreg <= sum[DATA_W-1:0];
          end
          rsp.done <= 1'b0;
          state    <= U_NEG_B;
        end
        U_NEG_B: begin
          // Divisor magnitude; the minimum value maps to 2^63 unsigned.
          if (b_neg) begin
            mreg <= sum[DATA_W-1:0];
          end
          acc      <= '0;
          count    <= '0;
          rsp.done <= 1'b0;
          state    <= U_DIV;
        end
        U_DIV: begin
          // Restoring divide: one quotient bit per cycle.
          if (sum[DATA_W]) begin
            acc <= sum[DATA_W-1:0];
          end else begin
            acc <= {acc[DATA_W-2:0], qreg[DATA_W-1]};
          end
          qreg     <= {qreg[DATA_W-2:0], sum[DATA_W]};
          count    <= count + ITER_W'(1);
          rsp.done <= 1'b0;
          if (last) begin
            state <= U_FIX;
          end
        end
        U_FIX: begin
          // Quotient is negative when signs differ; remainder follows the dividend.
          if (op_r == OP_DIV) begin
            result <= (a_neg ^ b_neg) ? sum[DATA_W-1:0] : qreg;
          end else begin
            result <= a_neg ? sum[DATA_W-1:0] : acc;
          end
          rsp.ok   <= 1'b1;
          rsp.done <= 1'b1;
          state    <= U_IDLE;
        end
        default: begin
          rsp.done <= 1'b0;
          state    <= U_IDLE;
        end
      endcase
    end
  end

  // A completion lasts exactly one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done)
    else $error("arith unit done held for more than one cycle");

  // A new request only arrives while the unit is free.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == U_IDLE)
    else $error("arith unit started while busy");

  // A divide or modulo by zero reports no fold.
  a_div_zero: assert property (@(posedge clk) disable iff (rst)
    (state == U_IDLE && req.start && (req.op == OP_DIV || req.op == OP_MOD) && b == '0)
      |=> rsp.done && !rsp.ok)
    else $error("divide by zero reported as folded");

endmodule

`default_nettype wire

[hdl/ir_constant_folder_top.sv]
// Top level of the IR constant folder: sequencer, temp store and arithmetic unit.
// A constant load goes straight to the output register; other ops read both sources back
// from the store, then add, sub, compare, logical and negate ops and a divide or modulo by
// zero finish in the unit at once, while multiply, divide and modulo run the shift-add and
// restoring-divide loops of the shared 64-bit adder. One item at a time; the next is
// taken the cycle after a result is handed to the output register. After reset a
// clearing pass sweeps all 1024 temp store entries before the first item; every 255th
// function start repeats that pass before its instruction runs.
`timescale 1ns / 1ps
`default_nettype none

module ir_constant_folder_top import ircf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  ircf_instr_if.sink          instr,
  ircf_result_if.source       result
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_RD_A,
    S_RD_B,
    S_RD_WAIT,
    S_EXEC,
    S_WAIT,
    S_PUT
  } state_t;

  state_t              state;
  logic [EPOCH_W-1:0]  epoch;
  logic [TEMP_W-1:0]   clear_addr;
  logic                pending;

  // Latched instruction.
  opcode_t             op_r;
  logic [TEMP_W-1:0]   dest_idx;
  logic [TEMP_W-1:0]   s1_idx;
  logic [TEMP_W-1:0]   s2_idx;
  logic                dest_ok;
  logic                s1_ok;
  logic                s2_ok;
  logic [DATA_W-1:0]   imm_r;

  // Operands and result.
  logic [DATA_W-1:0]   a_val;
  logic [DATA_W-1:0]   b_val;
  logic                k1;
  logic                k2;
  logic                res_folded;
  logic [DATA_W-1:0]   res_value;

  // Store and unit connections.
  logic                ram_we;
  logic [TEMP_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [TEMP_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic                tag_hit;
  logic                fold_go;
  arith_req_t          arith_req;
  arith_rsp_t          arith_rsp;
  logic [DATA_W-1:0]   arith_result;

  ircf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TEMP_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ircf_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (arith_req),
    .a      (a_val),
    .b      (b_val),
    .rsp    (arith_rsp),
    .result (arith_result)
  );

  // A stored entry is known when its tag matches the current epoch.
  assign tag_hit = (ram_rdata[ENTRY_W-1:DATA_W] == epoch);

  // Binary ops need both sources known; negate needs only the first.
  assign fold_go = dest_ok && k1 &&
                   ((k2 && op_r >= OP_ADD && op_r <= OP_OR) || op_r == OP_NEG);

  assign arith_req.start = (state == S_EXEC) && fold_go;
  assign arith_req.op    = op_r;

  assign instr.ready = (state == S_IDLE);

  // Store port control per phase.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = dest_idx;
    ram_wdata = {epoch, imm_r};
    ram_raddr = s1_idx;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clear_addr;
        ram_wdata = '0;
      end
      S_LOAD: begin
        ram_we = (op_r == OP_CONST) && dest_ok;
      end
      S_RD_B: begin
        ram_raddr = s2_idx;
      end
      S_WAIT: begin
        ram_we    = arith_rsp.done && arith_rsp.ok;
        ram_wdata = {epoch, arith_result};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Main sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      epoch        <= EPOCH_W'(1);
      clear_addr   <= '0;
      pending      <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      // The output register empties once its item is taken, unless refilled below.
      if (result.valid && result.ready && state != S_PUT) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          // Sweep every entry back to an unknown tag; the address wraps to zero.
          clear_addr <= clear_addr + TEMP_W'(1);
          if (clear_addr == TEMP_W'(TEMP_COUNT - 1)) begin
            pending <= 1'b0;
            state   <= pending ? S_LOAD : S_IDLE;
          end
        end
        S_IDLE: begin
          if (instr.valid) begin
            op_r     <= instr.opcode;
            dest_idx <= instr.dest_temp[TEMP_W-1:0];
            s1_idx   <= instr.first_source[TEMP_W-1:0];
            s2_idx   <= instr.second_source[TEMP_W-1:0];
            dest_ok  <= index_ok(instr.dest_temp);
            s1_ok    <= index_ok(instr.first_source);
            s2_ok    <= index_ok(instr.second_source);
            imm_r    <= instr.immediate;
            // A new epoch forgets every mark; on wrap the store is swept first.
            if (instr.function_start && epoch == '1) begin
              epoch   <= EPOCH_W'(1);
              pending <= 1'b1;
              state   <= S_CLEAR;
            end else begin
              if (instr.function_start) begin
                epoch <= epoch + EPOCH_W'(1);
              end
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          if (op_r == OP_CONST) begin
            res_folded <= 1'b0;
            res_value  <= '0;
            state      <= S_PUT;
          end else begin
            state <= S_RD_A;
          end
        end
        S_RD_A: begin
          state <= S_RD_B;
        end
        S_RD_B: begin
          a_val <= ram_rdata[DATA_W-1:0];
          k1    <= s1_ok && tag_hit;
          state <= S_RD_WAIT;
        end
        S_RD_WAIT: begin
          b_val <= ram_rdata[DATA_W-1:0];
          k2    <= s2_ok && tag_hit;
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (fold_go) begin
            state <= S_WAIT;
          end else begin
            res_folded <= 1'b0;
            res_value  <= '0;
            state      <= S_PUT;
          end
        end
        S_WAIT: begin
          if (arith_rsp.done) begin
            res_folded <= arith_rsp.ok;
            res_value  <= arith_rsp.ok ? arith_result : '0;
            state      <= S_PUT;
          end
        end
        S_PUT: begin
          // Hand over once the output register is free.
          if (!result.valid || result.ready) begin
            result.valid        <= 1'b1;
            result.folded       <= res_folded;
            result.folded_value <= res_value;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An item that does not fold reports a zero value.
  a_unfolded_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.folded |-> result.folded_value == '0)
    else $error("unfolded item carries a nonzero value");

  // The store is never written while source operands are being read back.
  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !(state == S_RD_B || state == S_RD_WAIT))
    else $error("store write during operand read");

  // The epoch never reaches the tag value used by the clearing pass.
  a_epoch_nonzero: assert property (@(posedge clk) disable iff (rst)
    epoch != '0)
    else $error("epoch reached the cleared tag value");

  // One item at a time: after an accept the block is busy.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    instr.valid && instr.ready |=> !instr.ready)
    else $error("item accepted while previous one in flight");

endmodule

`default_nettype wire

[tb/ircf_fold_checker.sv]
// Fold checker: watches both channels, tracks temp constants and compares each result item.
`timescale 1ns / 1ps

module ircf_fold_checker import ircf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  ircf_instr_if  instr,
  ircf_result_if result,
  output int     fold_errors,
  output int     folds_pending
);

  localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic              folded;
    logic [DATA_W-1:0] value;
  } fold_t;

  // Shadow copy of the per-temp known marks and constant values.
  logic              known_mark [TEMP_COUNT];
  logic [DATA_W-1:0] temp_value [TEMP_COUNT];
  fold_t             pending_folds [$];
  int                mismatch_cnt;

  // Applies one instruction to the shadow state and returns the fold outcome.
  function automatic fold_t fold_instr(input logic fs, input opcode_t op,
                                       input logic signed [INDEX_W-1:0] dst,
                                       input logic signed [INDEX_W-1:0] src_a,
                                       input logic signed [INDEX_W-1:0] src_b,
                                       input logic [DATA_W-1:0] imm);
    fold_t                    r;
    logic                     dst_ok;
    logic                     a_known;
    logic                     b_known;
    logic                     hit;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic [DATA_W-1:0]        v;
    r = '0;
    a_known = 1'b0;
    b_known = 1'b0;
    a = '0;
    b = '0;
    v = '0;
    hit = 1'b0;
    if (fs) begin
      foreach (known_mark[i]) known_mark[i] = 1'b0;
    end
    dst_ok = (dst >= 0) && (int'(dst) < TEMP_COUNT);
    if (op == OP_CONST && dst_ok) begin
      temp_value[int'(dst)] = imm;
      known_mark[int'(dst)] = 1'b1;
    end
    // A source is known only when its index is in range and its mark is set.
    if (src_a >= 0 && int'(src_a) < TEMP_COUNT && known_mark[int'(src_a)]) begin
      a_known = 1'b1;
      a = temp_value[int'(src_a)];
    end
    if (src_b >= 0 && int'(src_b) < TEMP_COUNT && known_mark[int'(src_b)]) begin
      b_known = 1'b1;
      b = temp_value[int'(src_b)];
    end
    // Binary operations need both sources known.
    if (dst_ok && a_known && b_known) begin
      hit = 1'b1;
      case (op)
        OP_ADD: v = a + b;
        OP_SUB: v = a - b;
        OP_MUL: v = a * b;
        OP_DIV: begin
          if (b == 0) hit = 1'b0;
          else if (a == VALUE_MIN && b == -1) v = a;
          else v = a / b;
        end
        OP_MOD: begin
          if (b == 0) hit = 1'b0;
          else if (a == VALUE_MIN && b == -1) v = '0;
          else v = a % b;
        end
        OP_LT:  v = DATA_W'(a < b);
        OP_GT:  v = DATA_W'(a > b);
        OP_LE:  v = DATA_W'(a <= b);
        OP_GE:  v = DATA_W'(a >= b);
        OP_EQ:  v = DATA_W'(a == b);
        OP_NE:  v = DATA_W'(a != b);
        OP_AND: v = DATA_W'((a != 0) && (b != 0));
        OP_OR:  v = DATA_W'((a != 0) || (b != 0));
        default: hit = 1'b0;
      endcase
    end
    // Negate folds on its first source alone.
    if (!hit && op == OP_NEG && dst_ok && a_known) begin
      hit = 1'b1;
      v = -a;
    end
    if (hit) begin
      temp_value[int'(dst)] = v;
      known_mark[int'(dst)] = 1'b1;
      r.folded = 1'b1;
      r.value = v;
    end
    return r;
  endfunction

  // Record accepted instructions, then compare accepted result items in order.
  always @(posedge clk) begin
    fold_t want;
    if (rst) begin
      foreach (known_mark[i]) known_mark[i] = 1'b0;
      pending_folds.delete();
    end else begin
      if (instr.valid && instr.ready) begin
        pending_folds.push_back(fold_instr(instr.function_start, instr.opcode,
                                           instr.dest_temp, instr.first_source,
                                           instr.second_source, instr.immediate));
      end
      if (result.valid && result.ready) begin
        if (pending_folds.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: unexpected result item: folded=%0b value=%h", $time,
                     result.folded, result.folded_value);
          end
        end else begin
          want = pending_folds.pop_front();
          if (want.folded !== result.folded || want.value !== result.folded_value) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: fold mismatch: expected folded=%0b value=%h, got folded=%0b value=%h",
                       $time, want.folded, want.value, result.folded, result.folded_value);
            end
          end
        end
      end
    end
    fold_errors <= mismatch_cnt;
    folds_pending <= pending_folds.size();
  end

endmodule

[tb/testbench.sv]
// Top of the constant folder testbench: clock, reset, instruction stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import ircf_pkg::*;

  localparam logic [DATA_W-1:0] VALUE_MIN = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int PHASE_ITEMS = 650;
  localparam int DIRECTED_ITEMS = 27;
  // The receiver holds off once, early in the phase without idling.
  localparam int HOLD_AT = DIRECTED_ITEMS + 2 * PHASE_ITEMS + 100;
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst;
  int   fold_errors;
  int   folds_pending;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   results_taken;
  int   hold_left;
  logic hold_done;

  ircf_instr_if  instr_ch ();
  ircf_result_if result_ch ();

  ir_constant_folder_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .result (result_ch)
  );

  ircf_fold_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .instr         (instr_ch),
    .result        (result_ch),
    .fold_errors   (fold_errors),
    .folds_pending (folds_pending)
  );

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result receiver: random stalls, plus one long hold-off that backs up the block.
  initial begin
    result_ch.ready <= 1'b0;
    results_taken = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) results_taken++;
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (!hold_done && results_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Offers one instruction item after a random gap and waits until it is taken.
  task automatic issue_instr(input logic fs, input opcode_t op,
                             input logic signed [INDEX_W-1:0] dst,
                             input logic signed [INDEX_W-1:0] src_a,
                             input logic signed [INDEX_W-1:0] src_b,
                             input logic [DATA_W-1:0] imm);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      instr_ch.valid <= 1'b0;
      @(posedge clk);
    end
    instr_ch.valid          <= 1'b1;
    instr_ch.function_start <= fs;
    instr_ch.opcode         <= op;
    instr_ch.dest_temp      <= dst;
    instr_ch.first_source   <= src_a;
    instr_ch.second_source  <= src_b;
    instr_ch.immediate      <= imm;
    @(posedge clk);
    while (!instr_ch.ready) @(posedge clk);
  endtask

  // Drops valid and waits until every result item has come back.
  task automatic drain_folds();
    instr_ch.valid <= 1'b0;
    @(posedge clk);
    while (folds_pending != 0) @(posedge clk);
  endtask

  // Temp index: mostly a small pool so that constants meet, sometimes anything.
  function automatic logic signed [INDEX_W-1:0] pick_temp();
    int sel;
    int neg;
    sel = $urandom_range(0, 99);
    neg = -int'($urandom_range(1, 1024));
    if (sel < 70) return INDEX_W'($urandom_range(0, 15));
    if (sel < 82) return INDEX_W'(1008 + $urandom_range(0, 15));
    if (sel < 92) return INDEX_W'($urandom_range(0, 1023));
    if (sel < 96) return -1;
    return neg[INDEX_W-1:0];
  endfunction

  // Immediate value: extremes, small signed values and full random words.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 64'd1;
      2: return '1;
      3: return VALUE_MIN;
      4: return VALUE_MAX;
      5, 6: return DATA_W'(longint'(int'($urandom_range(0, 16)) - 8));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One random item: mostly constant loads and folds over a small pool, some noise.
  task automatic issue_random_instr();
    logic    fs;
    opcode_t op;
    if ($urandom_range(0, 9) == 0) begin
      issue_instr(1'($urandom), opcode_t'($urandom_range(0, 15)), INDEX_W'($urandom),
                  INDEX_W'($urandom), INDEX_W'($urandom), {$urandom, $urandom});
    end else begin
      fs = ($urandom_range(0, 49) == 0);
      if ($urandom_range(0, 99) < 35) op = OP_CONST;
      else op = opcode_t'($urandom_range(1, 15));
      issue_instr(fs, op, pick_temp(), pick_temp(), pick_temp(), pick_value());
    end
  endtask

  // Reset, directed items, then three random phases with different idling.
  initial begin
    rst <= 1'b1;
    instr_ch.valid          <= 1'b0;
    instr_ch.function_start <= 1'b0;
    instr_ch.opcode         <= OP_OTHER;
    instr_ch.dest_temp      <= -1;
    instr_ch.first_source   <= -1;
    instr_ch.second_source  <= -1;
    instr_ch.immediate      <= '0;
    tx_idle_pct = 15;
    rx_idle_pct = 50;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Constant loads of the extreme values, of minus seven and of two.
    issue_instr(1'b1, OP_CONST, 0, -1, -1, VALUE_MIN);
    issue_instr(1'b0, OP_CONST, 1, -1, -1, '1);
    issue_instr(1'b0, OP_CONST, 2, -1, -1, '0);
    issue_instr(1'b0, OP_CONST, 3, -1, -1, VALUE_MAX);
    issue_instr(1'b0, OP_CONST, 1023, -1, -1, -64'sd7);
    issue_instr(1'b0, OP_CONST, 10, -1, -1, 64'd2);
    // Minimum divided by minus one, and division or modulo by zero.
    issue_instr(1'b0, OP_DIV, 4, 0, 1, '0);
    issue_instr(1'b0, OP_MOD, 5, 0, 1, '0);
    issue_instr(1'b0, OP_DIV, 6, 3, 2, '0);
    issue_instr(1'b0, OP_MOD, 7, 1023, 2, '0);
    // Rounding toward zero and the sign of the remainder.
    issue_instr(1'b0, OP_DIV, 11, 1023, 10, '0);
    issue_instr(1'b0, OP_MOD, 12, 1023, 10, '0);
    // Wrapping arithmetic.
    issue_instr(1'b0, OP_ADD, 13, 3, 3, '0);
    issue_instr(1'b0, OP_SUB, 14, 0, 1023, '0);
    issue_instr(1'b0, OP_MUL, 15, 3, 3, '0);
    // Compares and logical operations.
    issue_instr(1'b0, OP_LT, 16, 0, 1, '0);
    issue_instr(1'b0, OP_GT, 17, 3, 0, '0);
    issue_instr(1'b0, OP_LE, 18, 1, 1, '0);
    issue_instr(1'b0, OP_GE, 19, 2, 1, '0);
    issue_instr(1'b0, OP_EQ, 20, 1, 1, '0);
    issue_instr(1'b0, OP_NE, 21, 1, 2, '0);
    issue_instr(1'b0, OP_AND, 22, 1, 2, '0);
    issue_instr(1'b0, OP_OR, 23, 2, 10, '0);
    // Negate of the minimum with no second source, then an op that never folds.
    issue_instr(1'b0, OP_NEG, 24, 0, -1, '0);
    issue_instr(1'b0, OP_OTHER, 25, 1, 1, '0);
    // Missing destination, a negative destination, then a new function.
    issue_instr(1'b0, OP_ADD, -1, 1, 1, '0);
    issue_instr(1'b0, OP_CONST, 11'h400, -1, -1, 64'd5);
    issue_instr(1'b1, OP_ADD, 26, 1, 1, '0);

    repeat (PHASE_ITEMS) issue_random_instr();
    drain_folds();

    tx_idle_pct = 50;
    rx_idle_pct = 15;
    repeat (PHASE_ITEMS) issue_random_instr();
    drain_folds();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (PHASE_ITEMS) issue_random_instr();
    drain_folds();

    repeat (80) @(posedge clk);
    if (fold_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
